FILE: hdl/isc_pkg.sv
package isc_pkg;

    // pi in Q48 and the table size
    localparam logic [63:0] PI_Q48   = 64'h0003_243F_6A88_85A3;
    localparam int          TBL_SIZE = 256;
    localparam int          MAX_POS  = 32767;

    typedef logic signed [15:0] isc_tbl_t [0:TBL_SIZE-1];
    typedef logic [9:0]         isc_slope_tbl_t [0:TBL_SIZE-1];

    // Folded angle and radius after the first stage
    typedef struct packed {
        logic [15:0]        mag;
        logic               neg;
        logic               full;
        logic signed [15:0] radius;
    } isc_fold_t;

    // Table outputs after the lookup stage
    typedef struct packed {
        logic signed [15:0] sin_h;
        logic signed [15:0] cos_h;
        logic [9:0]         slope;
        logic               neg;
        logic               full;
        logic signed [15:0] radius;
    } isc_rom_t;

    // Slope corrections after the first multiply
    typedef struct packed {
        logic signed [15:0] sin_h;
        logic signed [15:0] cos_h;
        logic signed [26:0] corr_s;
        logic signed [26:0] corr_c;
        logic               neg;
        logic               full;
        logic signed [15:0] radius;
    } isc_corr_t;

    // Final factors ahead of the radius multiply
    typedef struct packed {
        logic signed [15:0] sin_f;
        logic signed [15:0] cos_f;
        logic signed [15:0] radius;
    } isc_factor_t;

    // (a*b) >> 40 without overflow, for operands below 2^42
    function automatic logic [63:0] mul_q40(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] bh;
        logic [63:0] bl;
        bh = b >> 21;
        bl = b & 64'h1F_FFFF;
        return ((a * bh) >> 19) + ((a * bl) >> 40);
    endfunction

    // Unsigned quotient by shift and subtract, used only while building tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(32768*sin(i*pi/128)) for i in 0..64, by a fixed-point series
    function automatic int quarter_sine(input int i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        den;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x   = (64'(i) * PI_Q48) >> 15;
        x2  = mul_q40(x, x);
        term = x;
        sum = signed'(x);
        for (int k = 1; k <= 12; k++) begin
            den  = 64'((2 * k) * (2 * k + 1));
            term = udiv64(mul_q40(term, x2), den);
            if (k % 2 == 1) sum = sum - signed'(term);
            else            sum = sum + signed'(term);
        end
        if (sum < 0) sum = '0;
        rnd = (unsigned'(sum) + (64'd1 << 24)) >> 25;
        return int'(rnd[31:0]);
    endfunction

    // Sine table, or cosine table when cos_sel is set, clamped to the top
    function automatic isc_tbl_t build_trig(input logic cos_sel);
        int       q [0:64];
        int       v;
        int       idx;
        isc_tbl_t tbl;
        for (int i = 0; i <= 64; i++) q[i] = quarter_sine(i);
        for (int i = 0; i < TBL_SIZE; i++) begin
            idx = cos_sel ? ((i + 64) % TBL_SIZE) : i;
            if (idx <= 64)       v = q[idx];
            else if (idx <= 128) v = q[128 - idx];
            else if (idx <= 192) v = -q[idx - 128];
            else                 v = -q[256 - idx];
            if (v > MAX_POS) v = MAX_POS;
            tbl[i] = 16'(v);
        end
        return tbl;
    endfunction

    // round(i*pi) for the low angle byte
    function automatic isc_slope_tbl_t build_slope();
        logic [63:0]    v;
        isc_slope_tbl_t tbl;
        for (int i = 0; i < TBL_SIZE; i++) begin
            v = (64'(i) * PI_Q48 + (64'd1 << 47)) >> 48;
            tbl[i] = v[9:0];
        end
        return tbl;
    endfunction

    localparam isc_tbl_t       SIN_ROM   = build_trig(1'b0);
    localparam isc_tbl_t       COS_ROM   = build_trig(1'b1);
    localparam isc_slope_tbl_t SLOPE_ROM = build_slope();

endpackage

FILE: hdl/isc_fold.sv
module isc_fold (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         in_angle,
    input  logic signed [15:0]  in_radius,
    output logic                out_valid,
    input  logic                out_ready,
    output isc_pkg::isc_rom_t   out_data
);
    import isc_pkg::*;

    logic      fold_vld_reg;
    isc_fold_t fold_reg;
    isc_fold_t fold_next;
    logic      rom_vld_reg;
    isc_rom_t  rom_reg;
    isc_rom_t  rom_next;
    logic      fold_rdy;
    logic      rom_rdy;

    // Advance a stage when it is empty or its successor takes its request
    assign rom_rdy  = !rom_vld_reg || out_ready;
    assign fold_rdy = !fold_vld_reg || rom_rdy;
    assign in_ready = fold_rdy;

    // Fold negative angles onto the positive half turn
    always_comb begin
        fold_next.neg    = in_angle[15];
        fold_next.full   = (in_angle == 16'h8000);
        fold_next.mag    = in_angle[15] ? (~in_angle + 16'd1) : in_angle;
        fold_next.radius = in_radius;
    end

    // Look up the coarse sine, cosine and the slope of the low byte
    always_comb begin
        rom_next.sin_h  = SIN_ROM[fold_reg.mag[15:8]];
        rom_next.cos_h  = COS_ROM[fold_reg.mag[15:8]];
        rom_next.slope  = SLOPE_ROM[fold_reg.mag[7:0]];
        rom_next.neg    = fold_reg.neg;
        rom_next.full   = fold_reg.full;
        rom_next.radius = fold_reg.radius;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_vld_reg <= 1'b0;
            rom_vld_reg  <= 1'b0;
        end else begin
            if (fold_rdy) fold_vld_reg <= in_valid;
            if (rom_rdy)  rom_vld_reg  <= fold_vld_reg;
        end
    end

    // Payload: load only on a moving request
    always_ff @(posedge aclk) begin
        if (fold_rdy && in_valid)     fold_reg <= fold_next;
        if (rom_rdy && fold_vld_reg)  rom_reg  <= rom_next;
    end

    assign out_valid = rom_vld_reg;
    assign out_data  = rom_reg;

endmodule

FILE: hdl/isc_interp.sv
module isc_interp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  isc_pkg::isc_rom_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output isc_pkg::isc_factor_t out_data
);
    import isc_pkg::*;

    logic        corr_vld_reg;
    isc_corr_t   corr_reg;
    isc_corr_t   corr_next;
    logic        fac_vld_reg;
    isc_factor_t fac_reg;
    isc_factor_t fac_next;
    logic        corr_rdy;
    logic        fac_rdy;
    logic signed [17:0] s_sum;
    logic signed [17:0] c_sum;
    logic signed [15:0] s_clamp;
    logic signed [15:0] c_clamp;

    assign fac_rdy  = !fac_vld_reg || out_ready;
    assign corr_rdy = !corr_vld_reg || fac_rdy;
    assign in_ready = corr_rdy;

    // Scale the coarse values by the slope of the low byte
    always_comb begin
        corr_next.sin_h  = in_data.sin_h;
        corr_next.cos_h  = in_data.cos_h;
        corr_next.corr_s = signed'({1'b0, in_data.slope}) * in_data.cos_h;
        corr_next.corr_c = signed'({1'b0, in_data.slope}) * in_data.sin_h;
        corr_next.neg    = in_data.neg;
        corr_next.full   = in_data.full;
        corr_next.radius = in_data.radius;
    end

    // Add the floored corrections, clamp, then unfold the sign
    always_comb begin
        s_sum = 18'(corr_reg.sin_h) + 18'(signed'(corr_reg.corr_s[26:15]));
        c_sum = 18'(corr_reg.cos_h) - 18'(signed'(corr_reg.corr_c[26:15]));
        if (s_sum > 18'sd32767) s_clamp = 16'sd32767;
        else                    s_clamp = s_sum[15:0];
        if (c_sum < -18'sd32768) c_clamp = -16'sd32767;
        else                     c_clamp = c_sum[15:0];
        if (corr_reg.full) begin
            fac_next.sin_f = '0;
            fac_next.cos_f = 16'h8000;
        end else begin
            fac_next.sin_f = corr_reg.neg ? -s_clamp : s_clamp;
            fac_next.cos_f = c_clamp;
        end
        fac_next.radius = corr_reg.radius;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_vld_reg <= 1'b0;
            fac_vld_reg  <= 1'b0;
        end else begin
            if (corr_rdy) corr_vld_reg <= in_valid;
            if (fac_rdy)  fac_vld_reg  <= corr_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (corr_rdy && in_valid)    corr_reg <= corr_next;
        if (fac_rdy && corr_vld_reg) fac_reg  <= fac_next;
    end

    assign out_valid = fac_vld_reg;
    assign out_data  = fac_reg;

endmodule

FILE: hdl/isc_scale.sv
module isc_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  isc_pkg::isc_factor_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   out_sine,
    output logic signed [15:0]   out_cosine
);
    import isc_pkg::*;

    logic               prod_vld_reg;
    logic signed [31:0] sin_prod_reg;
    logic signed [31:0] cos_prod_reg;
    logic signed [31:0] sin_prod_next;
    logic signed [31:0] cos_prod_next;
    logic               prod_rdy;

    assign prod_rdy = !prod_vld_reg || out_ready;
    assign in_ready = prod_rdy;

    // Multiply the radius by each factor
    assign sin_prod_next = in_data.radius * in_data.sin_f;
    assign cos_prod_next = in_data.radius * in_data.cos_f;

    always_ff @(posedge aclk) begin
        if (!aresetn) prod_vld_reg <= 1'b0;
        else if (prod_rdy) prod_vld_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (prod_rdy && in_valid) begin
            sin_prod_reg <= sin_prod_next;
            cos_prod_reg <= cos_prod_next;
        end
    end

    // Floor by 2^15 and wrap to 16 bits
    assign out_valid  = prod_vld_reg;
    assign out_sine   = sin_prod_reg[30:15];
    assign out_cosine = cos_prod_reg[30:15];

endmodule

FILE: hdl/interpolated_sine_cosine_scale.sv
// Interpolated sine/cosine scaler in 1.15 fixed point.
// Input stream (s_*): one request per item, tdata carries the angle (a full
// turn is 65536, read as signed) and a signed radius.
// Output stream (m_*): one request per item, tdata carries radius*sin and
// radius*cos, each floored by 2^15 and wrapped to 16 bits.
// Coarse values come from 256-entry sine and cosine tables indexed by the top
// angle byte; a slope table on the low byte adds a linear correction.
// Five register stages: fold, table lookup, slope multiply, add and clamp,
// radius multiply, in that order; m_tvalid is the last stage's valid bit.
// Throughput is one item per cycle while m_tready stays high; the five
// stages each hold one item.
// When the receiver stalls, results stay in their stages and s_tready drops
// only once every stage is full; bubbles are squeezed out meanwhile.
// Reset clears the stage valid bits only; nothing is kept between items and
// the tables are constant, so the block is ready in the cycle after reset.
module interpolated_sine_cosine_scale (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // angle [15:0], radius [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sine_product [15:0], cosine_product [31:16]
);
    import isc_pkg::*;

    logic               rom_valid;
    logic               rom_ready;
    isc_rom_t           rom_data;
    logic               fac_valid;
    logic               fac_ready;
    isc_factor_t        fac_data;
    logic signed [15:0] sine_product;
    logic signed [15:0] cosine_product;

    isc_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angle  (s_tdata[15:0]),
        .in_radius (signed'(s_tdata[31:16])),
        .out_valid (rom_valid),
        .out_ready (rom_ready),
        .out_data  (rom_data)
    );

    isc_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rom_valid),
        .in_ready  (rom_ready),
        .in_data   (rom_data),
        .out_valid (fac_valid),
        .out_ready (fac_ready),
        .out_data  (fac_data)
    );

    isc_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fac_valid),
        .in_ready   (fac_ready),
        .in_data    (fac_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sine   (sine_product),
        .out_cosine (cosine_product)
    );

    assign m_tdata = {cosine_product, sine_product};

endmodule

FILE: tb/sv/isc_product_checker.sv
`timescale 1ns / 100ps

module isc_product_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // angle [15:0], radius [31:16]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // sine_product [15:0], cosine_product [31:16]
    output int          mismatch_count,
    output int          products_due
);

    localparam real PI_R = 3.14159265358979323846;

    // Coarse sine and cosine per top angle byte, slope per low angle byte
    int sin_tbl   [0:255];
    int cos_tbl   [0:255];
    int slope_tbl [0:255];

    // Products still owed by the block, oldest first: {cosine, sine}
    logic [31:0] awaited_products [$];
    logic [31:0] want;

    // Fill the tables: rounded 1.15 values, positive side capped at full scale
    initial begin
        int raw [0:255];
        for (int i = 0; i < 256; i++) begin
            raw[i]       = int'(32768.0 * $sin(2.0 * PI_R * i / 256.0));
            slope_tbl[i] = int'(i * PI_R);
        end
        for (int i = 0; i < 256; i++) begin
            sin_tbl[i] = (raw[i] > 32767) ? 32767 : raw[i];
            cos_tbl[i] = (raw[(i + 64) % 256] > 32767) ? 32767 : raw[(i + 64) % 256];
        end
    end

    // Scale both interpolated factors by the radius; returns {cosine, sine}
    function automatic logic [31:0] scaled_sincos(input logic [15:0] angle,
                                                  input logic [15:0] radius);
        logic signed [15:0] sa;
        logic signed [15:0] sr;
        int                 mag;
        int                 hi;
        int                 lo;
        int                 s;
        int                 c;
        longint             sp;
        longint             cp;
        sa = angle;
        sr = radius;
        if (angle == 16'h8000) begin
            // half turn exactly: no interpolation
            s = 0;
            c = -32768;
        end else begin
            mag = (sa < 0) ? -int'(sa) : int'(sa);
            hi  = mag >> 8;
            lo  = mag & 255;
            s   = sin_tbl[hi] + int'((longint'(slope_tbl[lo]) * cos_tbl[hi]) >>> 15);
            if (s > 32767) s = 32767;
            c   = cos_tbl[hi] - int'((longint'(slope_tbl[lo]) * sin_tbl[hi]) >>> 15);
            if (c < -32768) c = -32767;
            // negative angles mirror the sine, keep the cosine
            if (sa < 0) s = -s;
        end
        sp = (longint'(sr) * s) >>> 15;
        cp = (longint'(sr) * c) >>> 15;
        return {cp[15:0], sp[15:0]};
    endfunction

    // Sample mid-cycle: every channel signal is stable between rising edges
    always @(negedge aclk) begin
        if (aresetn) begin
            // check a result request against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (awaited_products.size() == 0) begin
                    $display("%0t: unexpected result, actual sine %0d cosine %0d", $time,
                             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
                    mismatch_count++;
                end else begin
                    want = awaited_products.pop_front();
                    if (m_tdata[15:0] !== want[15:0]) begin
                        $display("%0t: sine_product expected %0d actual %0d", $time,
                                 $signed(want[15:0]), $signed(m_tdata[15:0]));
                        mismatch_count++;
                    end
                    if (m_tdata[31:16] !== want[31:16]) begin
                        $display("%0t: cosine_product expected %0d actual %0d", $time,
                                 $signed(want[31:16]), $signed(m_tdata[31:16]));
                        mismatch_count++;
                    end
                end
            end
            // predict for the request taken at the coming edge
            if (s_tvalid && s_tready)
                awaited_products.push_back(scaled_sincos(s_tdata[15:0], s_tdata[31:16]));
            products_due = awaited_products.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 400;
    localparam int DRAIN_CYCLES  = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // angle [15:0], radius [31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // sine_product [15:0], cosine_product [31:16]

    int mismatch_count;
    int products_due;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    interpolated_sine_cosine_scale i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    isc_product_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .products_due   (products_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Give up after a generous number of cycles
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL interpolated_sine_cosine_scale");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until taken
    task automatic send_item(input logic [15:0] angle, input logic [15:0] radius);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {radius, angle};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // Mostly uniform angles, with a share near the half turn, the
    // interpolation seams and the peaks where the clamps bite
    task automatic send_random();
        logic [15:0] angle;
        logic [15:0] radius;
        angle = 16'($urandom);
        case ($urandom_range(9))
            6: begin
                case ($urandom_range(7))
                    0: angle = 16'h8000;
                    1: angle = 16'h8001;
                    2: angle = 16'h7FFF;
                    3: angle = 16'hFFFF;
                    4: angle = 16'h0000;
                    5: angle = 16'h0001;
                    6: angle = 16'h4000;
                    default: angle = 16'hC000;
                endcase
            end
            7: angle[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
            8: angle[15:8] = 8'($urandom_range(8'h42, 8'h3D)) ^ {angle[15], 7'd0};
            9: angle[15:8] = 8'($urandom_range(8'h7F, 8'h7C)) ^ {angle[15], 7'd0};
            default: ;
        endcase
        radius = 16'($urandom);
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0: radius = 16'h8000;
                1: radius = 16'h7FFF;
                2: radius = 16'hFFFF;
                3: radius = 16'h0001;
                default: radius = 16'h0000;
            endcase
        end
        send_item(angle, radius);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero angle, quarter turns, half turn, seams and clamp regions
        send_item(16'h0000, 16'h7FFF);
        send_item(16'h0000, 16'h8000);
        send_item(16'h4000, 16'h7FFF);
        send_item(16'hC000, 16'h7FFF);
        send_item(16'h8000, 16'h8000);
        send_item(16'h8000, 16'h7FFF);
        send_item(16'h8001, 16'h8000);
        send_item(16'h7FFF, 16'h8000);
        send_item(16'h7FFF, 16'h7FFF);
        send_item(16'hFFFF, 16'h7FFF);
        send_item(16'h0001, 16'hFFFF);
        send_item(16'h3FFF, 16'h7FFF);
        send_item(16'h3FFF, 16'h8000);
        send_item(16'hC001, 16'h8000);
        send_item(16'h3F80, 16'h7FFF);
        send_item(16'h7F80, 16'h8000);
        send_item(16'h80FF, 16'h7FFF);
        send_item(16'h00FF, 16'h0001);
        send_item(16'h1234, 16'h0000);
        send_item(16'hA5A5, 16'h5A5A);
        send_item(16'h5A5A, 16'hA5A5);

        // no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  <= (phase == 1) ? 86 : (phase == 3) ? 26 : 0;
            stall_pct <= (phase == 2) ? 86 : (phase == 3) ? 26 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
                // hold off once until the pipeline has fully drained
                if (phase == 2 && n == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (products_due != 0) @(posedge aclk);
                end
            end
        end

        // drain, then allow for stray results
        s_tvalid  <= 1'b0;
        idle_pct  <= 0;
        stall_pct <= 0;
        @(posedge aclk);
        while (products_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS interpolated_sine_cosine_scale");
        end else begin
            $display("FAIL interpolated_sine_cosine_scale");
        end
        $finish;
    end

endmodule
